// ===== rtl/achp_pkg.sv =====
package achp_pkg;

    localparam int unsigned HASH_BYTES_DEFAULT = 16;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic        LAYOUT_RST       = 1'b1;
    localparam logic [10:0] MAX_PATHS_RST    = 11'd1500;
    localparam logic [15:0] MAX_PATH_LEN_RST = 16'd200;
    localparam logic [31:0] FORMAT_MASK      = 32'h0000FFFF;
    localparam logic [31:0] LENGTH_MAX       = 32'hFFFFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYOUT       = 2'd0,
        REG_MAX_PATHS    = 2'd1,
        REG_MAX_PATH_LEN = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        KIND_HASH      = 4'd0,
        KIND_COUNT     = 4'd1,
        KIND_PATH_LEN  = 4'd2,
        KIND_PATH_CHAR = 4'd3,
        KIND_ATTR_LEN  = 4'd4,
        KIND_ATTR_CHAR = 4'd5,
        KIND_PAD       = 4'd6,
        KIND_FORMAT    = 4'd7,
        KIND_IGNORED   = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_PATH_CNT  = 2'd1,
        ERR_PATH_LEN  = 2'd2
    } err_t;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_HASH      = 12'b0000_0000_0010,
        PH_COUNT     = 12'b0000_0000_0100,
        PH_PLEN      = 12'b0000_0000_1000,
        PH_PCHAR     = 12'b0000_0001_0000,
        PH_ALEN      = 12'b0000_0010_0000,
        PH_ACHAR     = 12'b0000_0100_0000,
        PH_PAD       = 12'b0000_1000_0000,
        PH_FMT       = 12'b0001_0000_0000,
        PH_DONE      = 12'b0010_0000_0000,
        PH_ERR_COUNT = 12'b0100_0000_0000,
        PH_ERR_LEN   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic        layout;
        logic [10:0] max_paths;
        logic [15:0] max_path_len;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  word_cnt;
        logic [31:0] acc;
        logic [10:0] paths_rem;
        logic [31:0] skip_rem;
        logic [10:0] cur_path;
        logic [31:0] bytes;
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] path_index;
        logic        done;
        logic [15:0] fmt;
        logic [31:0] length;
        err_t        err;
    } result_t;

endpackage

// ===== rtl/achp_cfg.sv =====
module achp_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [achp_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [achp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output achp_pkg::cfg_t                      cfg
);

    achp_pkg::cfg_t cfg_reg;
    achp_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx)
                achp_pkg::REG_LAYOUT:       cfg_next.layout       = cfg_data[0];
                achp_pkg::REG_MAX_PATHS:    cfg_next.max_paths    = cfg_data[10:0];
                achp_pkg::REG_MAX_PATH_LEN: cfg_next.max_path_len = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.layout       <= achp_pkg::LAYOUT_RST;
            cfg_reg.max_paths    <= achp_pkg::MAX_PATHS_RST;
            cfg_reg.max_path_len <= achp_pkg::MAX_PATH_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/achp_core.sv =====
module achp_core #(
    parameter int unsigned HASH_BYTES = achp_pkg::HASH_BYTES_DEFAULT,
    parameter int unsigned HASH_CNT_W = $clog2(HASH_BYTES + 2)
) (
    input  achp_pkg::state_t        state,
    input  logic [HASH_CNT_W-1:0]   hash_cnt,
    input  achp_pkg::cfg_t          cfg,
    input  logic [7:0]              byte_value,
    input  logic                    start_of_header,
    output achp_pkg::state_t        state_next,
    output logic [HASH_CNT_W-1:0]   hash_cnt_next,
    output achp_pkg::result_t       result
);

    localparam logic [HASH_CNT_W-1:0] HASH_LAST = HASH_CNT_W'(HASH_BYTES);
    localparam bit HAS_HASH = (HASH_BYTES > 0);

    always_comb begin
        achp_pkg::state_t        cur;
        logic [HASH_CNT_W-1:0]   hc;
        logic [31:0]             word;
        logic                    word_last;
        logic [10:0]             np_rem;
        logic [10:0]             np_path;
        achp_pkg::phase_t        np_phase;
        logic                    consumed;

        cur = state;
        hc  = hash_cnt;
        // A start byte clears the parse state before it is classified.
        if (start_of_header) begin
            cur       = '0;
            cur.phase = (cfg.layout && HAS_HASH) ? achp_pkg::PH_HASH : achp_pkg::PH_COUNT;
            hc        = '0;
        end

        word      = cur.acc | ({24'd0, byte_value} << {cur.word_cnt, 3'b000});
        word_last = (cur.word_cnt == 2'd3);

        np_rem   = cur.paths_rem - 11'd1;
        np_path  = cur.cur_path + 11'd1;
        np_phase = (cur.paths_rem == 11'd1) ? achp_pkg::PH_ALEN : achp_pkg::PH_PLEN;

        state_next        = cur;
        hash_cnt_next     = hc;
        result.kind       = achp_pkg::KIND_IGNORED;
        result.path_index = '0;
        result.done       = 1'b0;
        result.fmt        = '0;
        result.err        = achp_pkg::ERR_NONE;
        consumed          = 1'b1;

        unique case (cur.phase)
            achp_pkg::PH_HASH: begin
                result.kind   = achp_pkg::KIND_HASH;
                hash_cnt_next = hc + HASH_CNT_W'(1);
                if (hash_cnt_next == HASH_LAST) begin
                    hash_cnt_next    = '0;
                    state_next.phase = achp_pkg::PH_COUNT;
                end
            end
            achp_pkg::PH_COUNT: begin
                result.kind         = achp_pkg::KIND_COUNT;
                state_next.word_cnt = cur.word_cnt + 2'd1;
                state_next.acc      = word_last ? 32'd0 : word;
                if (word_last) begin
                    if (word > {21'd0, cfg.max_paths}) begin
                        result.err       = achp_pkg::ERR_PATH_CNT;
                        state_next.phase = achp_pkg::PH_ERR_COUNT;
                    end else begin
                        state_next.paths_rem = word[10:0];
                        state_next.cur_path  = '0;
                        state_next.phase     = (word == 32'd0) ? achp_pkg::PH_ALEN
                                                               : achp_pkg::PH_PLEN;
                    end
                end
            end
            achp_pkg::PH_PLEN: begin
                result.kind         = achp_pkg::KIND_PATH_LEN;
                result.path_index   = cur.cur_path;
                state_next.word_cnt = cur.word_cnt + 2'd1;
                state_next.acc      = word_last ? 32'd0 : word;
                if (word_last) begin
                    if (word > {16'd0, cfg.max_path_len}) begin
                        result.err       = achp_pkg::ERR_PATH_LEN;
                        state_next.phase = achp_pkg::PH_ERR_LEN;
                    end else if (word == 32'd0) begin
                        state_next.paths_rem = np_rem;
                        state_next.cur_path  = np_path;
                        state_next.phase     = np_phase;
                    end else begin
                        state_next.skip_rem = word;
                        state_next.phase    = achp_pkg::PH_PCHAR;
                    end
                end
            end
            achp_pkg::PH_PCHAR: begin
                result.kind         = achp_pkg::KIND_PATH_CHAR;
                result.path_index   = cur.cur_path;
                state_next.skip_rem = cur.skip_rem - 32'd1;
                if (cur.skip_rem == 32'd1) begin
                    state_next.paths_rem = np_rem;
                    state_next.cur_path  = np_path;
                    state_next.phase     = np_phase;
                end
            end
            achp_pkg::PH_ALEN: begin
                result.kind         = achp_pkg::KIND_ATTR_LEN;
                state_next.word_cnt = cur.word_cnt + 2'd1;
                state_next.acc      = word_last ? 32'd0 : word;
                if (word_last) begin
                    state_next.skip_rem = word;
                    state_next.phase    = (word == 32'd0) ? achp_pkg::PH_FMT
                                                          : achp_pkg::PH_ACHAR;
                end
            end
            achp_pkg::PH_ACHAR: begin
                result.kind         = achp_pkg::KIND_ATTR_CHAR;
                state_next.skip_rem = cur.skip_rem - 32'd1;
                if (cur.skip_rem == 32'd1) begin
                    state_next.phase = achp_pkg::PH_PAD;
                end
            end
            achp_pkg::PH_PAD: begin
                result.kind      = achp_pkg::KIND_PAD;
                state_next.phase = achp_pkg::PH_FMT;
            end
            achp_pkg::PH_FMT: begin
                result.kind = achp_pkg::KIND_FORMAT;
                if (!cfg.layout) begin
                    result.fmt  = {8'd0, byte_value};
                    result.done = 1'b1;
                end else begin
                    state_next.word_cnt = cur.word_cnt + 2'd1;
                    state_next.acc      = word_last ? 32'd0 : word;
                    if (word_last) begin
                        result.fmt  = 16'(word & achp_pkg::FORMAT_MASK);
                        result.done = 1'b1;
                    end
                end
                if (result.done) begin
                    state_next.phase = achp_pkg::PH_DONE;
                end
            end
            achp_pkg::PH_ERR_COUNT: begin
                consumed   = 1'b0;
                result.err = achp_pkg::ERR_PATH_CNT;
            end
            achp_pkg::PH_ERR_LEN: begin
                consumed   = 1'b0;
                result.err = achp_pkg::ERR_PATH_LEN;
            end
            default: begin
                consumed = 1'b0;
            end
        endcase

        if (consumed && (cur.bytes != achp_pkg::LENGTH_MAX)) begin
            state_next.bytes = cur.bytes + 32'd1;
        end
        result.length = state_next.bytes;
    end

endmodule

// ===== rtl/asset_common_header_parser.sv =====
// Asset header parser, one beat in and one beat out per header byte.
// The input channel (s_) carries a header byte and a start flag that marks
// the first byte of a new header and restarts the parser at any point.
// The result channel (m_) classifies each byte, gives the path index for
// path bytes, and on the last format byte raises header_done with the format
// value. header_length counts the bytes of the current header, and
// error_code reports a path count or path length above its limit, after
// which bytes are ignored until the next start.
// A beat accepted at an edge is registered and shown on the result channel
// after that edge. Throughput is one beat per cycle while the receiver
// takes each result, set by the single registered pass from the parse state
// through the byte logic to the result register; the parse state itself is
// updated at the same edge. When the receiver stalls, the result register
// holds its beat and s_ready drops until that beat is taken; taking it frees
// the register in the same cycle for the next beat.
// Reset sets the parser idle, clears the length and loads the register
// defaults: newer layout, path count limit 1500, path length limit 200.
// The user must write the configuration port only while no beat is in flight; the block does not enforce it.
module asset_common_header_parser #(
    parameter int unsigned HASH_BYTES = achp_pkg::HASH_BYTES_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [achp_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [achp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_byte_value,
    input  logic                             s_start_of_header,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [3:0]                       m_byte_kind,
    output logic [10:0]                      m_path_index,
    output logic                             m_header_done,
    output logic [15:0]                      m_format_value,
    output logic [31:0]                      m_header_length,
    output logic [1:0]                       m_error_code
);

    localparam int unsigned HASH_CNT_W = $clog2(HASH_BYTES + 2);

    achp_pkg::cfg_t          cfg;
    achp_pkg::state_t        state_reg;
    achp_pkg::state_t        state_next;
    logic [HASH_CNT_W-1:0]   hash_cnt_reg;
    logic [HASH_CNT_W-1:0]   hash_cnt_next;
    achp_pkg::result_t       result_reg;
    achp_pkg::result_t       result_next;
    logic                    m_valid_reg;
    logic                    accept;

    achp_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    achp_core #(
        .HASH_BYTES (HASH_BYTES),
        .HASH_CNT_W (HASH_CNT_W)
    ) u_core (
        .state           (state_reg),
        .hash_cnt        (hash_cnt_reg),
        .cfg             (cfg),
        .byte_value      (s_byte_value),
        .start_of_header (s_start_of_header),
        .state_next      (state_next),
        .hash_cnt_next   (hash_cnt_next),
        .result          (result_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= achp_pkg::PH_IDLE;
            state_reg.word_cnt  <= '0;
            state_reg.acc       <= '0;
            state_reg.paths_rem <= '0;
            state_reg.skip_rem  <= '0;
            state_reg.cur_path  <= '0;
            state_reg.bytes     <= '0;
            hash_cnt_reg        <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (accept) begin
                state_reg    <= state_next;
                hash_cnt_reg <= hash_cnt_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_byte_kind     = result_reg.kind;
    assign m_path_index    = result_reg.path_index;
    assign m_header_done   = result_reg.done;
    assign m_format_value  = result_reg.fmt;
    assign m_header_length = result_reg.length;
    assign m_error_code    = result_reg.err;

`ifndef SYNTHESIS
    a_done_is_format: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_header_done |-> m_byte_kind == achp_pkg::KIND_FORMAT)
        else $error("header_done on a byte that is not a format byte");

    a_format_only_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_format_value != 16'd0) |-> m_header_done)
        else $error("format value shown without header_done");

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat produced no result");

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_start_of_header |=> state_reg.phase != achp_pkg::PH_IDLE)
        else $error("parser idle after a start beat");
`endif

endmodule
